// ----- sv/lsc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsc_pkg
// Shared types and constants of the level-set curvature kernel.
// ----------------------------------------------------------------------------
package lsc_pkg;

   // quotient bits of both divisions; the root of G/Dn is taken in Q30
   localparam int DIV_STEPS  = 61;
   localparam int G_SHIFT    = 60;
   localparam int Q_BITS     = 12;
   localparam int ROOT_W     = 31;
   localparam int POST_SHIFT = Q_BITS + 31;
   localparam int OUT_W      = 24;
   localparam int EPS_W      = 16;
   localparam logic [EPS_W-1:0] EPS_RESET = 16'd1;

   // register map
   localparam int CSR_AW   = 3;
   localparam int CSR_DW   = 32;
   localparam logic REG_EPS = 1'b0;

   typedef struct packed {
      logic valid;
      logic neg;
      logic zero;
   } lsc_ctl_type;

endpackage

// ----- sv/level_set_curvature_kernel.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// level_set_curvature_kernel
// Level-set mean curvature of one 3x3 phi neighborhood per beat.
//
//   port group   dir  payload
//   req_*        in   tdata: nine phi samples, tuser: in_band
//   rsp_*        out  tdata: curvature_out, tuser: saturated_flag
//   csr_*        in   epsilon_value at byte address 0
//
// One beat is accepted per cycle unless rsp_tready stalls the pipeline; stages are 4 front
// stages, 61 divider stages, 31 square-root stages, 2 multiply stages and the output register.
// The divider, one quotient bit per stage, sets the depth.
// reset clears every valid bit and sets epsilon_value to 1.
// A stall on rsp_tready freezes the whole pipeline; req_tready follows it.
// ----------------------------------------------------------------------------
module level_set_curvature_kernel #(
   parameter int PHI_WIDTH = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // center, up, down, left, right, up_left, up_right, down_left, down_right
   input  logic [((9*PHI_WIDTH+7)/8)*8-1:0]  req_tdata,
   // in_band
   input  logic                              req_tuser,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // curvature_out
   output logic [lsc_pkg::OUT_W-1:0]         rsp_tdata,
   // saturated_flag
   output logic                              rsp_tuser,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [lsc_pkg::CSR_AW-1:0]        csr_paddr,
   input  logic [lsc_pkg::CSR_DW-1:0]        csr_pwdata,
   output logic [lsc_pkg::CSR_DW-1:0]        csr_prdata,
   output logic                              csr_pready
);
   localparam int P     = PHI_WIDTH;
   localparam int GW    = 2*P + 1;
   localparam int DW    = 2*P + 2;
   localparam int MW    = 3*P + 5;
   localparam int ST    = lsc_pkg::DIV_STEPS;
   localparam int NUMW  = DW + ST;
   localparam int AW    = P + 16;
   localparam int RW    = lsc_pkg::ROOT_W;
   localparam int FLO   = 16;
   localparam int PRW   = AW + RW;
   localparam int MAGW  = PRW - lsc_pkg::POST_SHIFT;
   localparam int OW    = lsc_pkg::OUT_W;
   localparam int CW    = ((MAGW > OW) ? MAGW : OW) + 1;

   logic                      adv;
   logic [lsc_pkg::EPS_W-1:0] eps_ff;
   logic                      csr_wr;

   lsc_pkg::lsc_ctl_type fr_ctl, dv_ctl, sq_ctl, m1_ctl_ff, m2_ctl_ff;
   logic [GW-1:0]        fr_g;
   logic [DW-1:0]        fr_den;
   logic [MW-1:0]        fr_mag;
   logic [NUMW-1:0]      num_g, num_m;
   logic [ST-1:0]        quo_g, quo_m;
   logic [RW-1:0]        root;
   logic [AW-1:0]        a_q;
   logic [AW+FLO-1:0]    plo_ff;
   logic [PRW-FLO-1:0]   phi_ff;
   logic [PRW-1:0]       prod;
   logic [MAGW-1:0]      mag_ff;
   logic [CW-1:0]        mag_c;
   logic                 sat_in;
   logic [OW-1:0]        res_in;
   logic                 rsp_valid_ff, rsp_sat_ff;
   logic [OW-1:0]        rsp_data_ff;

   assign adv        = !rsp_valid_ff || rsp_tready;
   assign req_tready = adv;

   // configuration
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         eps_ff <= lsc_pkg::EPS_RESET;
      end else if (csr_wr && csr_paddr[2] == lsc_pkg::REG_EPS) begin
         eps_ff <= csr_pwdata[lsc_pkg::EPS_W-1:0];
      end
   end

   assign csr_prdata = (csr_paddr[2] == lsc_pkg::REG_EPS) ?
                       lsc_pkg::CSR_DW'(eps_ff) : '0;

   lsc_front #(.PHI_WIDTH(P)) u_front (
      .clock    (clock),
      .reset    (reset),
      .en       (adv),
      .in_valid (req_tvalid),
      .in_phi   (req_tdata[9*P-1:0]),
      .in_band  (req_tuser),
      .eps      (eps_ff),
      .out_ctl  (fr_ctl),
      .out_g    (fr_g),
      .out_den  (fr_den),
      .out_mag  (fr_mag)
   );

   // G/Dn in Q60 and |N2|/Dn in Q12
   assign num_g = NUMW'(fr_g) << lsc_pkg::G_SHIFT;
   assign num_m = NUMW'(fr_mag) << lsc_pkg::Q_BITS;

   lsc_divider #(.DW(DW), .STEPS(ST)) u_div (
      .clock     (clock),
      .reset     (reset),
      .en        (adv),
      .in_ctl    (fr_ctl),
      .in_den    (fr_den),
      .in_num_a  (num_g),
      .in_num_b  (num_m),
      .out_ctl   (dv_ctl),
      .out_quo_a (quo_g),
      .out_quo_b (quo_m)
   );

   lsc_sqrt #(.RW(RW), .PW(AW)) u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .en       (adv),
      .in_ctl   (dv_ctl),
      .in_x     ((2*RW)'(quo_g)),
      .in_side  (quo_m[AW-1:0]),
      .out_ctl  (sq_ctl),
      .out_root (root),
      .out_side (a_q)
   );

   // a*f split over the low and high halves of the root
   assign prod  = PRW'(plo_ff) + (PRW'(phi_ff) << FLO);
   assign mag_c = CW'(mag_ff);

   always_comb begin
      if (m2_ctl_ff.neg) begin
         sat_in = mag_c > (CW'(1) << (OW-1));
      end else begin
         sat_in = mag_c > ((CW'(1) << (OW-1)) - CW'(1));
      end
      if (m2_ctl_ff.zero) begin
         sat_in = 1'b0;
         res_in = '0;
      end else if (sat_in) begin
         res_in = m2_ctl_ff.neg ? {1'b1, {(OW-1){1'b0}}} : {1'b0, {(OW-1){1'b1}}};
      end else begin
         res_in = m2_ctl_ff.neg ? OW'(CW'(0) - mag_c) : OW'(mag_c);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         m1_ctl_ff    <= '0;
         m2_ctl_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         m1_ctl_ff    <= sq_ctl;
         m2_ctl_ff    <= m1_ctl_ff;
         rsp_valid_ff <= m2_ctl_ff.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         plo_ff      <= a_q * root[FLO-1:0];
         phi_ff      <= a_q * root[RW-1:FLO];
         mag_ff      <= prod[PRW-1:lsc_pkg::POST_SHIFT];
         rsp_data_ff <= res_in;
         rsp_sat_ff  <= sat_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_sat_ff;

   a_sat_at_limit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_sat_ff |->
         rsp_data_ff == {1'b1, {(OW-1){1'b0}}} || rsp_data_ff == {1'b0, {(OW-1){1'b1}}})
      else $error("saturation flag without a clipped value");

   a_zero_item: assert property (@(posedge clock) disable iff (reset)
      adv && m2_ctl_ff.valid && m2_ctl_ff.zero |=> rsp_data_ff == '0 && !rsp_sat_ff)
      else $error("out-of-band or flat item gave a nonzero result");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      !adv |=> $stable(m1_ctl_ff) && $stable(m2_ctl_ff) && $stable(mag_ff))
      else $error("pipeline moved during a stall");

   a_ready_free: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid_ff |-> req_tready)
      else $error("input stalled with an empty output register");

endmodule

// ----- sv/lsc_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsc_front
// Differences, products, numerator and denominator in four register stages.
// ----------------------------------------------------------------------------
module lsc_front #(
   parameter int PHI_WIDTH = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                en,
   input  logic                                in_valid,
   input  logic [9*PHI_WIDTH-1:0]              in_phi,
   input  logic                                in_band,
   input  logic [lsc_pkg::EPS_W-1:0]           eps,
   output lsc_pkg::lsc_ctl_type                out_ctl,
   output logic [2*PHI_WIDTH:0]                out_g,
   output logic [2*PHI_WIDTH+1:0]              out_den,
   output logic [3*PHI_WIDTH+4:0]              out_mag
);
   localparam int P  = PHI_WIDTH;
   localparam int GW = 2*P + 1;
   localparam int DW = 2*P + 2;
   localparam int TW = 3*P + 4;
   localparam int NW = 3*P + 6;
   localparam int MW = 3*P + 5;

   logic signed [P-1:0] c_s, u_s, d_s, l_s, r_s, ul_s, ur_s, dl_s, dr_s;

   // stage 1
   logic signed [P:0]   px_in, py_in, px_ff, py_ff;
   logic signed [P+2:0] pxx_in, pyy_in, s_in, pxx_ff, pyy_ff, s_ff;
   logic                v1_ff, b1_ff;
   // stage 2
   logic signed [2*P+1:0] pxsq, pysq, pxy_in, pxy_ff;
   logic [2*P-1:0]        px2_ff, py2_ff;
   logic signed [P+2:0]   pxx2_ff, pyy2_ff, s2_ff;
   logic                  v2_ff, b2_ff;
   // stage 3
   logic [GW-1:0]         g_in, g3_ff;
   logic signed [TW-1:0]  t1_in, t2_in, t3_in, t1_ff, t2_ff, t3_ff;
   logic                  v3_ff, b3_ff;
   // stage 4
   logic signed [NW-1:0]  n2;
   logic [MW-1:0]         mag_in, mag_ff;
   logic [DW-1:0]         den_in, den_ff;
   logic [GW-1:0]         g4_ff;
   lsc_pkg::lsc_ctl_type  ctl_in, ctl_ff;

   assign c_s  = in_phi[0*P +: P];
   assign u_s  = in_phi[1*P +: P];
   assign d_s  = in_phi[2*P +: P];
   assign l_s  = in_phi[3*P +: P];
   assign r_s  = in_phi[4*P +: P];
   assign ul_s = in_phi[5*P +: P];
   assign ur_s = in_phi[6*P +: P];
   assign dl_s = in_phi[7*P +: P];
   assign dr_s = in_phi[8*P +: P];

   assign px_in  = (P+1)'(r_s) - (P+1)'(l_s);
   assign py_in  = (P+1)'(u_s) - (P+1)'(d_s);
   assign pxx_in = (P+3)'(l_s) + (P+3)'(r_s) - ((P+3)'(c_s) <<< 1);
   assign pyy_in = (P+3)'(u_s) + (P+3)'(d_s) - ((P+3)'(c_s) <<< 1);
   assign s_in   = (P+3)'(dr_s) + (P+3)'(ul_s) - (P+3)'(dl_s) - (P+3)'(ur_s);

   assign pxsq   = px_ff * px_ff;
   assign pysq   = py_ff * py_ff;
   assign pxy_in = px_ff * py_ff;

   assign g_in  = GW'(px2_ff) + GW'(py2_ff);
   assign t1_in = $signed({1'b0, px2_ff}) * pyy2_ff;
   assign t2_in = $signed({1'b0, py2_ff}) * pxx2_ff;
   assign t3_in = pxy_ff * s2_ff;

   assign n2     = ((NW'(t1_ff) + NW'(t2_ff)) <<< 1) - NW'(t3_ff);
   assign mag_in = n2[NW-1] ? MW'(-n2) : MW'(n2);
   assign den_in = DW'(g3_ff) + DW'(eps);

   always_comb begin
      ctl_in.valid = v3_ff;
      ctl_in.neg   = n2[NW-1];
      ctl_in.zero  = !b3_ff || (g3_ff == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff  <= 1'b0;
         v2_ff  <= 1'b0;
         v3_ff  <= 1'b0;
         ctl_ff <= '0;
      end else if (en) begin
         v1_ff  <= in_valid;
         v2_ff  <= v1_ff;
         v3_ff  <= v2_ff;
         ctl_ff <= ctl_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         px_ff   <= px_in;
         py_ff   <= py_in;
         pxx_ff  <= pxx_in;
         pyy_ff  <= pyy_in;
         s_ff    <= s_in;
         b1_ff   <= in_band;
         px2_ff  <= pxsq[2*P-1:0];
         py2_ff  <= pysq[2*P-1:0];
         pxy_ff  <= pxy_in;
         pxx2_ff <= pxx_ff;
         pyy2_ff <= pyy_ff;
         s2_ff   <= s_ff;
         b2_ff   <= b1_ff;
         g3_ff   <= g_in;
         t1_ff   <= t1_in;
         t2_ff   <= t2_in;
         t3_ff   <= t3_in;
         b3_ff   <= b2_ff;
         g4_ff   <= g3_ff;
         den_ff  <= den_in;
         mag_ff  <= mag_in;
      end
   end

   assign out_ctl = ctl_ff;
   assign out_g   = g4_ff;
   assign out_den = den_ff;
   assign out_mag = mag_ff;

endmodule

// ----- sv/lsc_divider.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsc_divider
// Pipelined restoring divider, one quotient bit per stage, two numerators
// over one shared divisor. The upper DW numerator bits must stay below den.
// ----------------------------------------------------------------------------
module lsc_divider #(
   parameter int DW    = 34,
   parameter int STEPS = 61
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     en,
   input  lsc_pkg::lsc_ctl_type     in_ctl,
   input  logic [DW-1:0]            in_den,
   input  logic [DW+STEPS-1:0]      in_num_a,
   input  logic [DW+STEPS-1:0]      in_num_b,
   output lsc_pkg::lsc_ctl_type     out_ctl,
   output logic [STEPS-1:0]         out_quo_a,
   output logic [STEPS-1:0]         out_quo_b
);
   logic [DW-1:0]        rem_a_ff [STEPS];
   logic [DW-1:0]        rem_b_ff [STEPS];
   logic [STEPS-1:0]     low_a_ff [STEPS];
   logic [STEPS-1:0]     low_b_ff [STEPS];
   logic [STEPS-1:0]     quo_a_ff [STEPS];
   logic [STEPS-1:0]     quo_b_ff [STEPS];
   logic [DW-1:0]        den_ff   [STEPS];
   lsc_pkg::lsc_ctl_type ctl_ff   [STEPS];

   for (genvar k = 0; k < STEPS; k++) begin : g_step
      logic [DW-1:0]        rem_a_src, rem_b_src, den_src;
      logic [STEPS-1:0]     low_a_src, low_b_src, quo_a_src, quo_b_src;
      lsc_pkg::lsc_ctl_type ctl_src;
      logic [DW:0]          cand_a, cand_b;
      logic                 ge_a, ge_b;

      if (k == 0) begin : g_head
         assign rem_a_src = in_num_a[DW+STEPS-1:STEPS];
         assign rem_b_src = in_num_b[DW+STEPS-1:STEPS];
         assign low_a_src = in_num_a[STEPS-1:0];
         assign low_b_src = in_num_b[STEPS-1:0];
         assign quo_a_src = '0;
         assign quo_b_src = '0;
         assign den_src   = in_den;
         assign ctl_src   = in_ctl;
      end else begin : g_body
         assign rem_a_src = rem_a_ff[k-1];
         assign rem_b_src = rem_b_ff[k-1];
         assign low_a_src = low_a_ff[k-1];
         assign low_b_src = low_b_ff[k-1];
         assign quo_a_src = quo_a_ff[k-1];
         assign quo_b_src = quo_b_ff[k-1];
         assign den_src   = den_ff[k-1];
         assign ctl_src   = ctl_ff[k-1];
      end

      assign cand_a = {rem_a_src, low_a_src[STEPS-1]};
      assign cand_b = {rem_b_src, low_b_src[STEPS-1]};
      assign ge_a   = cand_a >= {1'b0, den_src};
      assign ge_b   = cand_b >= {1'b0, den_src};

      always_ff @(posedge clock) begin
         if (reset) begin
            ctl_ff[k] <= '0;
         end else if (en) begin
            ctl_ff[k] <= ctl_src;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_a_ff[k] <= ge_a ? DW'(cand_a - {1'b0, den_src}) : cand_a[DW-1:0];
            rem_b_ff[k] <= ge_b ? DW'(cand_b - {1'b0, den_src}) : cand_b[DW-1:0];
            low_a_ff[k] <= {low_a_src[STEPS-2:0], 1'b0};
            low_b_ff[k] <= {low_b_src[STEPS-2:0], 1'b0};
            quo_a_ff[k] <= {quo_a_src[STEPS-2:0], ge_a};
            quo_b_ff[k] <= {quo_b_src[STEPS-2:0], ge_b};
            den_ff[k]   <= den_src;
         end
      end
   end

   assign out_ctl   = ctl_ff[STEPS-1];
   assign out_quo_a = quo_a_ff[STEPS-1];
   assign out_quo_b = quo_b_ff[STEPS-1];

endmodule

// ----- sv/lsc_sqrt.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsc_sqrt
// Pipelined integer square root, one root bit per stage; a side word rides
// along with each item.
// ----------------------------------------------------------------------------
module lsc_sqrt #(
   parameter int RW = 31,
   parameter int PW = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  en,
   input  lsc_pkg::lsc_ctl_type  in_ctl,
   input  logic [2*RW-1:0]       in_x,
   input  logic [PW-1:0]         in_side,
   output lsc_pkg::lsc_ctl_type  out_ctl,
   output logic [RW-1:0]         out_root,
   output logic [PW-1:0]         out_side
);
   logic [RW:0]          rem_ff  [RW];
   logic [RW-1:0]        root_ff [RW];
   logic [2*RW-1:0]      xs_ff   [RW];
   logic [PW-1:0]        side_ff [RW];
   lsc_pkg::lsc_ctl_type ctl_ff  [RW];

   for (genvar k = 0; k < RW; k++) begin : g_step
      logic [RW:0]          rem_src;
      logic [RW-1:0]        root_src;
      logic [2*RW-1:0]      xs_src;
      logic [PW-1:0]        side_src;
      lsc_pkg::lsc_ctl_type ctl_src;
      logic [RW+2:0]        cand, trial;
      logic                 ge;

      if (k == 0) begin : g_head
         assign rem_src  = '0;
         assign root_src = '0;
         assign xs_src   = in_x;
         assign side_src = in_side;
         assign ctl_src  = in_ctl;
      end else begin : g_body
         assign rem_src  = rem_ff[k-1];
         assign root_src = root_ff[k-1];
         assign xs_src   = xs_ff[k-1];
         assign side_src = side_ff[k-1];
         assign ctl_src  = ctl_ff[k-1];
      end

      // bring down the next bit pair, try root*4+1
      assign cand  = {rem_src, xs_src[2*RW-1 -: 2]};
      assign trial = {1'b0, root_src, 2'b01};
      assign ge    = cand >= trial;

      always_ff @(posedge clock) begin
         if (reset) begin
            ctl_ff[k] <= '0;
         end else if (en) begin
            ctl_ff[k] <= ctl_src;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k]  <= ge ? (RW+1)'(cand - trial) : cand[RW:0];
            root_ff[k] <= {root_src[RW-2:0], ge};
            xs_ff[k]   <= {xs_src[2*RW-3:0], 2'b00};
            side_ff[k] <= side_src;
         end
      end
   end

   assign out_ctl  = ctl_ff[RW-1];
   assign out_root = root_ff[RW-1];
   assign out_side = side_ff[RW-1];

endmodule

// ----- bench/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the level-set curvature kernel: pixel neighborhoods
// are streamed in under random back-pressure, each beat is predicted in fixed
// point and every result beat is checked in order against that prediction,
// over several epsilon settings.
// ----------------------------------------------------------------------------
typedef struct {
   logic [23:0] curv;
   logic        sat;
} curv_beat_type;

class curvature_scoreboard;
   curv_beat_type pending_q[$];
   logic [15:0]   eps;
   int            mismatches;

   function new();
      eps = lsc_pkg::EPS_RESET;
      mismatches = 0;
   endfunction

   function automatic logic [63:0] root64(logic [63:0] t);
      logic [63:0] res;
      logic [63:0] probe;
      res = 0;
      probe = 64'd1 << 62;
      while (probe > t) probe = probe >> 2;
      while (probe != 0) begin
         if (t >= res + probe) begin
            t = t - (res + probe);
            res = (res >> 1) + probe;
         end else begin
            res = res >> 1;
         end
         probe = probe >> 2;
      end
      return res;
   endfunction

   function automatic longint sample(logic [143:0] d, int k);
      logic signed [15:0] v;
      v = d[16*k +: 16];
      return longint'(v);
   endfunction

   // predict one neighborhood and queue the expected beat
   function void note_pixel(logic [143:0] d, logic band);
      longint c, u, dn, l, r, ul, ur, dl, dr;
      longint px, py, pxx, pyy, s, n2;
      logic [63:0] g, den, mag, f, a;
      logic [127:0] wide;
      logic neg;
      curv_beat_type e;
      c = sample(d, 0); u = sample(d, 1); dn = sample(d, 2);
      l = sample(d, 3); r = sample(d, 4); ul = sample(d, 5);
      ur = sample(d, 6); dl = sample(d, 7); dr = sample(d, 8);
      e.curv = 0;
      e.sat = 0;
      px = r - l;
      py = u - dn;
      g = px * px + py * py;
      if (band && g != 0) begin
         pxx = l + r - 2 * c;
         pyy = u + dn - 2 * c;
         s = dr + ul - dl - ur;
         n2 = 2 * (px * px * pyy + py * py * pxx) - px * py * s;
         neg = n2 < 0;
         mag = neg ? -n2 : n2;
         den = g + eps;
         wide = ({64'd0, g} << lsc_pkg::G_SHIFT) / {64'd0, den};
         f = root64(wide[63:0]);
         wide = ({64'd0, mag} << lsc_pkg::Q_BITS) / {64'd0, den};
         a = wide[63:0];
         wide = ({64'd0, a} * {64'd0, f}) >> lsc_pkg::POST_SHIFT;
         if (!neg && wide > 128'h7F_FFFF) begin
            wide = 128'h7F_FFFF;
            e.sat = 1;
         end else if (neg && wide > 128'h80_0000) begin
            wide = 128'h80_0000;
            e.sat = 1;
         end
         e.curv = neg ? -wide[23:0] : wide[23:0];
      end
      pending_q.push_back(e);
   endfunction

   task report(string what, logic [23:0] got, logic [23:0] want);
      $display("mismatch %s: got %h expected %h", what, got, want);
      mismatches++;
   endtask

   task check_beat(logic [23:0] curv, logic sat);
      curv_beat_type e;
      if (pending_q.size() == 0) begin
         report("unexpected beat", curv, 0);
      end else begin
         e = pending_q.pop_front();
         if (curv !== e.curv) report("curvature_out", curv, e.curv);
         if (sat !== e.sat) report("saturated_flag", {23'd0, sat}, {23'd0, e.sat});
      end
   endtask
endclass

module tb_top;
   logic          clock = 0;
   logic          reset = 1;
   logic          req_tvalid = 0;
   logic          req_tready;
   logic [143:0]  req_tdata = 0;
   logic          req_tuser = 0;
   logic          rsp_tvalid;
   logic          rsp_tready = 0;
   logic [23:0]   rsp_tdata;
   logic          rsp_tuser;
   logic          csr_psel = 0;
   logic          csr_penable = 0;
   logic          csr_pwrite = 0;
   logic [lsc_pkg::CSR_AW-1:0] csr_paddr = 0;
   logic [lsc_pkg::CSR_DW-1:0] csr_pwdata = 0;
   logic [lsc_pkg::CSR_DW-1:0] csr_prdata;
   logic          csr_pready;

   localparam int IDLE_PCT = 28;
   localparam int STALL_LIMIT = 5000;
   localparam logic [lsc_pkg::CSR_AW-1:0] EPS_ADDR = 3'd0;
   localparam logic [lsc_pkg::CSR_AW-1:0] SPARE_ADDR = 3'd4;

   curvature_scoreboard sb = new();
   bit calm = 0;
   int quiet_cycles = 0;

   level_set_curvature_kernel i_dut (.*);

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   always @(posedge clock) begin
      rsp_tready <= calm || ($urandom_range(99) >= IDLE_PCT);
      if (!reset && rsp_tvalid && rsp_tready) sb.check_beat(rsp_tdata, rsp_tuser);
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_psel)
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   task csr_write(logic [lsc_pkg::CSR_AW-1:0] addr, logic [31:0] value);
      logic [31:0] want;
      want = (addr == EPS_ADDR) ? {16'd0, value[15:0]} : 32'd0;
      csr_psel <= 1; csr_pwrite <= 1; csr_penable <= 0;
      csr_paddr <= addr; csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1;
      @(posedge clock);
      csr_psel <= 0; csr_penable <= 0; csr_pwrite <= 0;
      if (addr == EPS_ADDR) sb.eps = value[15:0];
      @(posedge clock);
      // read back the register at the address still on the bus
      if (csr_pready !== 1'b1 || csr_prdata !== want)
         sb.report("csr readback", csr_prdata[23:0], want[23:0]);
   endtask

   task send_pixel(logic [143:0] d, logic band);
      while (!calm && $urandom_range(99) < IDLE_PCT) begin
         req_tvalid <= 0;
         @(posedge clock);
      end
      req_tvalid <= 1;
      req_tdata <= d;
      req_tuser <= band;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sb.note_pixel(d, band);
   endtask

   // hold until every result is back, then let the pipe drain
   task drain();
      req_tvalid <= 0;
      while (sb.pending_q.size() != 0) @(posedge clock);
      repeat (120) @(posedge clock);
   endtask

   function automatic logic [143:0] fill(logic signed [15:0] v);
      return {9{v}};
   endfunction

   function automatic logic [143:0] rand_pixel();
      logic [143:0] d;
      logic signed [15:0] base;
      int span;
      base = 16'($urandom);
      span = 1 << $urandom_range(15);
      for (int k = 0; k < 9; k++) begin
         if ($urandom_range(3) == 0)
            d[16*k +: 16] = 16'($urandom);
         else
            d[16*k +: 16] = 16'(base + $signed($urandom_range(2 * span)) - span);
      end
      return d;
   endfunction

   task random_phase(int count);
      for (int n = 0; n < count; n++)
         send_pixel(rand_pixel(), $urandom_range(9) != 0);
      drain();
   endtask

   initial begin
      logic [143:0] d;
      repeat (10) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: flat, extremes, zero gradient, out of band, steep edges
      send_pixel(144'd0, 1);
      send_pixel(fill(16'sh7FFF), 1);
      send_pixel(fill(-16'sh8000), 1);
      send_pixel({9{16'hFFFF}}, 0);
      send_pixel({9{16'h5A5A}} ^ {72{2'b01}}, 0);
      d = {16'sh7FFF, -16'sh8000, 16'sh7FFF, -16'sh8000, 16'sh7FFF,
           -16'sh8000, 16'sh7FFF, -16'sh8000, 16'sh7FFF};
      send_pixel(d, 1);
      send_pixel(~d, 1);
      d = {16'sh7FFF, -16'sh8000, -16'sh8000, 16'sh7FFF, 16'sh7FFF,
           -16'sh8000, 16'sh7FFF, 16'sh7FFF, -16'sh8000};
      send_pixel(d, 1);
      send_pixel(~d, 1);
      d = 144'd0; d[16*4 +: 16] = 16'sh0001;
      send_pixel(d, 1);
      d = 144'd0; d[16*1 +: 16] = 16'sh0001; d[0 +: 16] = -16'sh8000;
      send_pixel(d, 1);
      d = 144'd0; d[16*2 +: 16] = -16'sh8000; d[16*4 +: 16] = 16'sh7FFF;
      d[16*5 +: 16] = 16'sh7FFF;
      send_pixel(d, 1);
      drain();

      csr_write(SPARE_ADDR, 32'h0000_1234);
      csr_write(EPS_ADDR, 32'hFFFF_0000);
      send_pixel(d, 1);
      d = 144'd0; d[16*4 +: 16] = 16'sh0001;
      send_pixel(d, 1);
      send_pixel(144'd0, 1);
      random_phase(500);

      csr_write(EPS_ADDR, {16'($urandom_range(16'hFFFF)), 16'hFFFF});
      send_pixel(d, 1);
      random_phase(500);

      calm = 1;
      csr_write(EPS_ADDR, $urandom);
      random_phase(400);
      calm = 0;

      csr_write(EPS_ADDR, 32'd1);
      random_phase(600);

      if (sb.mismatches == 0 && sb.pending_q.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end
endmodule

// ----- files.f -----
sv/lsc_pkg.sv
sv/lsc_front.sv
sv/lsc_divider.sv
sv/lsc_sqrt.sv
sv/level_set_curvature_kernel.sv
bench/tb_top.sv
